FILE: hdl/rgbshp_pkg.sv
// Shared types, constants and the per-channel sharpen function for the RGB sharpen stream.
package rgbshp_pkg;

    // Line geometry
    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WCNT_W    = $clog2(MAX_WIDTH + 1);

    // Register and field widths
    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int STR_W      = 6;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int PIX_W      = NUM_CH * CH_W;
    localparam int LINE_W     = 2 * PIX_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int WT_W       = 7;
    localparam int SUM_W      = 16;

    // Kernel constants
    localparam int CENTRE_BASE = 4;
    localparam int CH_MAX      = 255;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH     = 2'd2;

    // Register reset values
    localparam logic [FW_W-1:0]         FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FH_W-1:0]         FRAME_HEIGHT_RST = 16'd480;
    localparam logic signed [STR_W-1:0] STRENGTH_RST     = 6'sd1;

    // Input commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic            command;
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } pix_item_t;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic            last_pixel;
    } res_item_t;

    // One line memory word: row above and current row at one column
    typedef struct packed {
        logic [PIX_W-1:0] up_px;
        logic [PIX_W-1:0] mid_px;
    } line_word_t;

    // Effective frame geometry
    typedef struct packed {
        logic [ADDR_W-1:0] last_col;
        logic [FH_W-1:0]   last_row;
    } geom_t;

    // Per-item decode from the sequencer
    typedef struct packed {
        logic [ADDR_W-1:0] col;
        logic              advance;
        logic              mem_write;
        logic              produce;
        logic              up_valid;
        logic              at_left;
        logic              at_right;
        logic              last;
    } ctrl_t;

    // Cross kernel on one channel, clamped to 0..255
    function automatic logic [CH_W-1:0] sharpen_channel(
        input logic signed [WT_W-1:0] weight,
        input logic [CH_W-1:0]        centre,
        input logic [CH_W-1:0]        up,
        input logic [CH_W-1:0]        left,
        input logic [CH_W-1:0]        right,
        input logic [CH_W-1:0]        down
    );
        logic signed [SUM_W-1:0] sum;
        logic [CH_W-1:0]         res;
        sum = SUM_W'(weight) * $signed(SUM_W'(centre))
            - $signed(SUM_W'(up)) - $signed(SUM_W'(left))
            - $signed(SUM_W'(right)) - $signed(SUM_W'(down));
        if (sum < 0)
            res = '0;
        else if (sum > SUM_W'(CH_MAX))
            res = CH_W'(CH_MAX);
        else
            res = sum[CH_W-1:0];
        return res;
    endfunction

endpackage

FILE: hdl/rgbshp_line_ram.sv
// Simple dual-port line memory with registered read data (read-old on collision).
module rgbshp_line_ram #(
    parameter int DATA_W = 48,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/rgbshp_ctrl.sv
// Frame sequencer: column/row counters, fill and drain phases, per-item decode.
module rgbshp_ctrl
    import rgbshp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  logic  command,
    input  logic  restart,
    input  geom_t geom,
    output ctrl_t ctrl
);

    logic              drain_reg, drain_next;
    logic [ADDR_W-1:0] col_reg, col_next;
    logic [FH_W-1:0]   row_reg, row_next;
    logic              step_pixel;
    logic              step_flush;

    // Decode the item at the port against the current phase
    always_comb
    begin
        step_pixel     = !drain_reg && (command == CMD_PIXEL);
        step_flush     = drain_reg && (command == CMD_FLUSH);
        ctrl.col       = col_reg;
        ctrl.advance   = step_pixel || step_flush;
        ctrl.mem_write = step_pixel;
        ctrl.produce   = step_flush || (step_pixel && (row_reg != '0));
        ctrl.up_valid  = step_flush ? (geom.last_row != '0) : (row_reg > FH_W'(1));
        ctrl.at_left   = (col_reg == '0);
        ctrl.at_right  = (col_reg == geom.last_col);
        ctrl.last      = step_flush && (col_reg == geom.last_col);
    end

    // Counter update on each transfer that does work, and clear on restart
    always_comb
    begin
        drain_next = drain_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        if (restart)
        begin
            drain_next = 1'b0;
            col_next   = '0;
            row_next   = '0;
        end
        else if (accept && ctrl.advance)
        begin
            if (ctrl.at_right)
            begin
                col_next = '0;
                if (step_pixel)
                begin
                    if (row_reg == geom.last_row)
                    begin
                        drain_next = 1'b1;
                        row_next   = '0;
                    end
                    else
                    begin
                        row_next = row_reg + FH_W'(1);
                    end
                end
                else
                begin
                    // final flush closes the frame
                    drain_next = 1'b0;
                    row_next   = '0;
                end
            end
            else
            begin
                col_next = col_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg <= 1'b0;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            drain_reg <= drain_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

endmodule

FILE: hdl/rgbshp_kernel.sv
// Three-channel sharpen datapath over the five cross taps.
module rgbshp_kernel
    import rgbshp_pkg::*;
(
    input  logic signed [WT_W-1:0] weight,
    input  logic [PIX_W-1:0]       up_px,
    input  logic [PIX_W-1:0]       left_px,
    input  logic [PIX_W-1:0]       centre_px,
    input  logic [PIX_W-1:0]       right_px,
    input  logic [PIX_W-1:0]       down_px,
    output logic [PIX_W-1:0]       sharp_px
);

    // Channels are independent
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            sharp_px[ch*CH_W +: CH_W] = sharpen_channel(weight,
                centre_px[ch*CH_W +: CH_W], up_px[ch*CH_W +: CH_W],
                left_px[ch*CH_W +: CH_W], right_px[ch*CH_W +: CH_W],
                down_px[ch*CH_W +: CH_W]);
        end
    end

endmodule

FILE: hdl/rgbshp_out_skid.sv
// Result register plus skid entry so the input side keeps flowing under output stalls.
module rgbshp_out_skid
    import rgbshp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  res_item_t push_item,
    output logic      has_room,
    output logic      res_valid,
    input  logic      res_ready,
    output res_item_t res_data
);

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    res_item_t out_data_reg, out_data_next;
    res_item_t skid_data_reg, skid_data_next;
    logic      take;

    assign has_room  = !skid_valid_reg;
    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    // Refill the output register from skid first, then from the new item
    always_comb
    begin
        take            = out_valid_reg && res_ready;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_item;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_item;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

`ifndef SYNTHESIS
    // skid only ever holds the second of two waiting results
    assert property (@(posedge clk) disable iff (!rst_n) skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // no new result may arrive while the skid entry is full
    assert property (@(posedge clk) disable iff (!rst_n) !(push && skid_valid_reg))
        else $error("result pushed into full skid stage");
`endif

endmodule

FILE: hdl/rgb_sharpen_3x3_stream.sv
// Top level: config registers, line memory, cross-window taps and result staging.
// A result is registered in the output register, or in the skid entry while the output is stalled.
// Throughput: one item per cycle while the output side has room; results lag pixel input by one row,
// and the last row leaves on flush items, one per cycle while the output side has room.
// The single line memory (one write, one read per cycle) sets the one-item-per-cycle rate.
// Reset clears counters and loads 640 x 480, strength 1; line memory is not cleared.
module rgb_sharpen_3x3_stream
    import rgbshp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_ready,
    input  pix_item_t             pix_data,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_item_t             res_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Line memory is read two columns ahead of the pixel being written
    localparam int READ_AHEAD = 2;

    logic [FW_W-1:0]         fw_reg;
    logic [FH_W-1:0]         fh_reg;
    logic signed [STR_W-1:0] str_reg;

    geom_t                   geom;
    ctrl_t                   ctrl;
    logic [WCNT_W-1:0]       w_eff;
    logic                    single_col;
    logic                    geom_write;
    logic                    accept;
    logic                    step;
    logic                    push;
    logic                    has_room;

    logic [WCNT_W:0]         rd_sum, rd_wrap1, rd_wrap2, w_ext;
    logic [ADDR_W-1:0]       rd_addr;
    logic [LINE_W-1:0]       rd_data;

    line_word_t              centre_reg;
    logic [PIX_W-1:0]        left_reg;
    line_word_t              wr_hold_reg;
    logic                    fwd_reg;

    line_word_t              right_word;
    line_word_t              wr_word;
    logic [PIX_W-1:0]        pix_px;
    logic [PIX_W-1:0]        tap_up, tap_left, tap_right, tap_down;
    logic [PIX_W-1:0]        sharp_px;
    logic signed [WT_W-1:0]  centre_wt;
    res_item_t               push_item;

    assign cfg_ready = 1'b1;
    assign geom_write = cfg_valid && cfg_ready
                     && ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg  <= FRAME_WIDTH_RST;
            fh_reg  <= FRAME_HEIGHT_RST;
            str_reg <= STRENGTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  fw_reg  <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: fh_reg  <= cfg_data[FH_W-1:0];
                REG_STRENGTH:     str_reg <= $signed(cfg_data[STR_W-1:0]);
                default:          ;
            endcase
        end
    end

    // Effective geometry: zero acts as one, width clamps to the line memory
    always_comb
    begin
        if (fw_reg == '0)
            w_eff = WCNT_W'(1);
        else if (32'(fw_reg) > 32'(MAX_WIDTH))
            w_eff = WCNT_W'(MAX_WIDTH);
        else
            w_eff = WCNT_W'(fw_reg);
        geom.last_col = ADDR_W'(w_eff - WCNT_W'(1));
        geom.last_row = (fh_reg == '0) ? '0 : fh_reg - FH_W'(1);
        single_col    = (w_eff == WCNT_W'(1));
    end

    assign centre_wt = WT_W'(CENTRE_BASE) + WT_W'(str_reg);

    assign pix_ready = has_room;
    assign accept    = pix_valid && pix_ready;
    assign step      = accept && ctrl.advance;
    assign push      = step && ctrl.produce;

    rgbshp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .command (pix_data.command),
        .restart (geom_write),
        .geom    (geom),
        .ctrl    (ctrl)
    );

    // Look-ahead read address: (col + 2) mod width
    always_comb
    begin
        w_ext    = (WCNT_W+1)'(w_eff);
        rd_sum   = (WCNT_W+1)'(ctrl.col) + (WCNT_W+1)'(READ_AHEAD);
        rd_wrap1 = (rd_sum >= w_ext) ? rd_sum - w_ext : rd_sum;
        rd_wrap2 = (rd_wrap1 >= w_ext) ? rd_wrap1 - w_ext : rd_wrap1;
        rd_addr  = rd_wrap2[ADDR_W-1:0];
    end

    assign pix_px  = {pix_data.red_in, pix_data.green_in, pix_data.blue_in};
    assign wr_word = '{up_px: centre_reg.mid_px, mid_px: pix_px};

    rgbshp_line_ram #(
        .DATA_W (LINE_W),
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (accept && ctrl.mem_write),
        .wr_addr (ctrl.col),
        .wr_data (wr_word),
        .rd_en   (step),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Forward the word written in the same cycle as a colliding read
    assign right_word = fwd_reg ? wr_hold_reg : line_word_t'(rd_data);

    // Tap selection with edge replication
    always_comb
    begin
        tap_up    = ctrl.up_valid ? centre_reg.up_px : centre_reg.mid_px;
        tap_left  = ctrl.at_left ? centre_reg.mid_px : left_reg;
        tap_right = ctrl.at_right ? centre_reg.mid_px : right_word.mid_px;
        tap_down  = (pix_data.command == CMD_FLUSH) ? centre_reg.mid_px : pix_px;
    end

    rgbshp_kernel u_kernel (
        .weight    (centre_wt),
        .up_px     (tap_up),
        .left_px   (tap_left),
        .centre_px (centre_reg.mid_px),
        .right_px  (tap_right),
        .down_px   (tap_down),
        .sharp_px  (sharp_px)
    );

    always_comb
    begin
        push_item.red_out    = sharp_px[2*CH_W +: CH_W];
        push_item.green_out  = sharp_px[CH_W +: CH_W];
        push_item.blue_out   = sharp_px[0 +: CH_W];
        push_item.last_pixel = ctrl.last;
    end

    rgbshp_out_skid u_out_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .has_room  (has_room),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // Forwarding flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (step)
        begin
            fwd_reg <= ctrl.mem_write && (rd_addr == ctrl.col);
        end
    end

    // Window shift: right tap (written word for a single-column frame) becomes centre, centre becomes left
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            left_reg    <= centre_reg.mid_px;
            centre_reg  <= single_col ? wr_word : right_word;
            wr_hold_reg <= wr_word;
        end
    end

`ifndef SYNTHESIS
    // column counter stays inside the active line
    assert property (@(posedge clk) disable iff (!rst_n) ctrl.col <= geom.last_col)
        else $error("column counter beyond frame width");

    // forwarding is only raised by a transfer that wrote the line memory
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fwd_reg) |-> $past(step && ctrl.mem_write))
        else $error("forwarding flag set without a line write");

    // the frame-closing flush returns the sequencer to column zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && ctrl.last) |=> (ctrl.col == '0))
        else $error("column not cleared after last pixel");
`endif

endmodule
